>>> hdl/pmm_pkg.sv
// Package with the shared types and constants of the per-identifier message period monitor.
package pmm_pkg;

   localparam int unsigned NUM_SLOTS_DEF = 16;

   localparam int ID_W       = 11;
   localparam int TIME_W     = 32;
   localparam int SLOT_OUT_W = 4;
   localparam int ANOM_W     = 16;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef logic [1:0] reg_index_type;

   localparam reg_index_type REG_FIRST_ID   = 2'd0;
   localparam reg_index_type REG_LAST_ID    = 2'd1;
   localparam reg_index_type REG_PERIOD_MIN = 2'd2;
   localparam reg_index_type REG_PERIOD_MAX = 2'd3;

   localparam logic [ID_W-1:0]   FIRST_ID_RST   = 11'd0;
   localparam logic [ID_W-1:0]   LAST_ID_RST    = 11'd9;
   localparam logic [TIME_W-1:0] PERIOD_MIN_RST = '0;
   localparam logic [TIME_W-1:0] PERIOD_MAX_RST = '1;

   typedef struct packed {
      logic [ID_W-1:0]   can_id;
      logic [TIME_W-1:0] arrival_time;
   } req_type;

   typedef struct packed {
      logic                  tracked;
      logic [SLOT_OUT_W-1:0] slot;
      logic [TIME_W-1:0]     msg_count;
      logic                  has_interval;
      logic [TIME_W-1:0]     interval;
      logic                  out_of_period;
      logic [ANOM_W-1:0]     anomaly_total;
      logic [TIME_W-1:0]     least_interval;
      logic [TIME_W-1:0]     greatest_interval;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]   first_id;
      logic [ID_W-1:0]   last_id;
      logic [TIME_W-1:0] period_min;
      logic [TIME_W-1:0] period_max;
   } cfg_type;

   typedef struct packed {
      logic [TIME_W-1:0] prev_time;
      logic [TIME_W-1:0] msg_count;
      logic [ANOM_W-1:0] anomaly_total;
      logic [TIME_W-1:0] least_interval;
      logic [TIME_W-1:0] greatest_interval;
   } entry_type;

   localparam entry_type ENTRY_RST = '{
      prev_time:         '0,
      msg_count:         '0,
      anomaly_total:     '0,
      least_interval:    '1,
      greatest_interval: '0
   };

endpackage

>>> hdl/pmm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module pmm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> hdl/pmm_csr.sv
// Configuration register file of the message period monitor with its APB-style port.
module pmm_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [pmm_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [pmm_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [pmm_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready,
   output pmm_pkg::cfg_type                 cfg
);

   import pmm_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_idx;
   logic          wr_en;

   assign reg_idx = reg_index_type'(paddr[3:2]);
   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_FIRST_ID:   cfg_in.first_id   = pwdata[ID_W-1:0];
            REG_LAST_ID:    cfg_in.last_id    = pwdata[ID_W-1:0];
            REG_PERIOD_MIN: cfg_in.period_min = pwdata[TIME_W-1:0];
            REG_PERIOD_MAX: cfg_in.period_max = pwdata[TIME_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_FIRST_ID:   prdata = CSR_DATA_W'(cfg_ff.first_id);
         REG_LAST_ID:    prdata = CSR_DATA_W'(cfg_ff.last_id);
         REG_PERIOD_MIN: prdata = CSR_DATA_W'(cfg_ff.period_min);
         REG_PERIOD_MAX: prdata = CSR_DATA_W'(cfg_ff.period_max);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_id   <= FIRST_ID_RST;
         cfg_ff.last_id    <= LAST_ID_RST;
         cfg_ff.period_min <= PERIOD_MIN_RST;
         cfg_ff.period_max <= PERIOD_MAX_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hdl/per_id_message_period_monitor.sv
// Top level of the per-identifier message period monitor.
//
//   Channel  Ports                          Moves
//   req      req_valid, req_stall, req_data  identifier and arrival time in
//   rsp      rsp_valid, rsp_stall, rsp_data  updated slot statistics out
//   csr      psel .. pready                  window and period limits
//
// One transaction is accepted per cycle while req_stall is low; it is held in the stage-1 register,
// and its result becomes valid once it is loaded into the result register.
// The slot table is a RAM with a registered read, read when the transaction is accepted and
// written when it moves on to the result register; a bypass register covers back-to-back hits
// on the same slot.
// Reset clears the per-slot valid bits, so the table needs no clearing pass.
// A stalled result holds the transaction in flight and stalls the input side only when both
// stages are full.
module per_id_message_period_monitor #(
   parameter int NUM_SLOTS = pmm_pkg::NUM_SLOTS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  pmm_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output pmm_pkg::rsp_type               rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [pmm_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [pmm_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [pmm_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);

   import pmm_pkg::*;

   localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int ENTRY_W = $bits(entry_type);

   cfg_type cfg;

   logic              req_acc;
   logic              s1_adv;
   logic [ID_W-1:0]   s0_off;
   logic              s0_tracked;
   logic [SLOT_W-1:0] s0_idx;

   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_tracked_ff;
   logic [SLOT_W-1:0]     s1_idx_ff;
   logic [SLOT_OUT_W-1:0] s1_slot_ff;
   logic [TIME_W-1:0]     s1_time_ff;

   logic [NUM_SLOTS-1:0] seen_ff, seen_in;
   logic                 byp_valid_ff, byp_valid_in;
   logic [SLOT_W-1:0]    byp_idx_ff;
   entry_type            byp_data_ff;

   logic [ENTRY_W-1:0] ram_rdata;
   logic               tbl_we;
   logic               s1_seen;
   entry_type          cur;
   entry_type          nxt;
   logic [TIME_W-1:0]  delta;
   logic               bad;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   pmm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign s1_adv    = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_acc   = req_valid && !req_stall;

   always_comb begin
      s0_off     = req_data.can_id - cfg.first_id;
      s0_tracked = (req_data.can_id >= cfg.first_id) && (req_data.can_id <= cfg.last_id) &&
                   (32'(s0_off) < 32'(NUM_SLOTS));
      s0_idx     = s0_off[SLOT_W-1:0];
   end

   assign tbl_we = s1_valid_ff && s1_adv && s1_tracked_ff;

   pmm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_SLOTS)
   ) u_table (
      .clock (clock),
      .we    (tbl_we),
      .waddr (s1_idx_ff),
      .wdata (nxt),
      .re    (req_acc),
      .raddr (s0_idx),
      .rdata (ram_rdata)
   );

   always_comb begin
      s1_seen = seen_ff[s1_idx_ff];
      if (!s1_seen) begin
         cur = ENTRY_RST;
      end else if (byp_valid_ff && (byp_idx_ff == s1_idx_ff)) begin
         cur = byp_data_ff;
      end else begin
         cur = entry_type'(ram_rdata);
      end
      delta = s1_time_ff - cur.prev_time;
      bad   = s1_seen && ((delta > cfg.period_max) || (delta < cfg.period_min));

      nxt               = cur;
      nxt.prev_time     = s1_time_ff;
      nxt.msg_count     = cur.msg_count + TIME_W'(1);
      nxt.anomaly_total = cur.anomaly_total + ANOM_W'(bad);
      if (s1_seen && (delta < cur.least_interval)) begin
         nxt.least_interval = delta;
      end
      if (s1_seen && (delta > cur.greatest_interval)) begin
         nxt.greatest_interval = delta;
      end

      rsp_data_in = '0;
      if (s1_tracked_ff) begin
         rsp_data_in.tracked           = 1'b1;
         rsp_data_in.slot              = s1_slot_ff;
         rsp_data_in.msg_count         = nxt.msg_count;
         rsp_data_in.has_interval      = s1_seen;
         rsp_data_in.interval          = s1_seen ? delta : '0;
         rsp_data_in.out_of_period     = bad;
         rsp_data_in.anomaly_total     = nxt.anomaly_total;
         rsp_data_in.least_interval    = nxt.least_interval;
         rsp_data_in.greatest_interval = nxt.greatest_interval;
      end
   end

   always_comb begin
      s1_valid_in = s1_adv ? req_acc : (s1_valid_ff || req_acc);
      seen_in     = seen_ff;
      if (tbl_we) begin
         seen_in[s1_idx_ff] = 1'b1;
      end
      byp_valid_in = byp_valid_ff || tbl_we;
      rsp_valid_in = s1_adv ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         seen_ff      <= '0;
         byp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         seen_ff      <= seen_in;
         byp_valid_ff <= byp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_tracked_ff <= s0_tracked;
         s1_idx_ff     <= s0_idx;
         s1_slot_ff    <= s0_off[SLOT_OUT_W-1:0];
         s1_time_ff    <= req_data.arrival_time;
      end
      if (tbl_we) begin
         byp_idx_ff  <= s1_idx_ff;
         byp_data_ff <= nxt;
      end
      if (s1_adv && s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
